### rtl/lateral_offset_path_selector_assert.svh
// Assertion macros for the lateral offset path selector checkers.
`ifndef LATERAL_OFFSET_PATH_SELECTOR_ASSERT_SVH
`define LATERAL_OFFSET_PATH_SELECTOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define LPS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define LPS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/lps_pkg.sv
// Shared types, constants and sigmoid table builder for the path selector.
package lps_pkg;

	typedef struct packed {
		logic signed [15:0] obstacle_x;
		logic signed [15:0] obstacle_y;
		logic [9:0]         obstacle_radius;
	} plan_req_t;

	typedef struct packed {
		logic signed [11:0] best_offset;
		logic [23:0]        best_cost;
		logic               path_found;
	} plan_res_t;

	typedef enum logic [2:0] {
		REG_MAX_OFFSET  = 3'd0,
		REG_LAT_STEP    = 3'd1,
		REG_POINT_COUNT = 3'd2,
		REG_LON_STEP    = 3'd3,
		REG_CLEARANCE   = 3'd4,
		REG_W_CENTER    = 3'd5,
		REG_W_OBSTACLE  = 3'd6,
		REG_W_SMOOTH    = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		cfg_reg_t    index;
		logic [11:0] value;
	} cfg_wr_t;

	localparam int SIG_W = 17;
	localparam logic [17:0] NEAR_COST = 18'd256000;
	// 100*d2 <= 65536 in Q16.16 is d2 <= 655
	localparam int NEAR_D2_MAX = 655;
	localparam longint unsigned Q30_ONE = 64'd1073741824;
	localparam longint unsigned E_INV_Q30 = 64'd395007542;

	// Elaboration-time long division for the table builder.
	function automatic longint unsigned lps_udiv(input longint unsigned num,
		input longint unsigned den);
		longint unsigned q;
		longint unsigned r;
		q = 0;
		r = 0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[62:0], num[b]};
			if (r >= den) begin
				r = r - den;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// Sigmoid entry u of a depth-entry table, Q1.16.
	function automatic logic [SIG_W-1:0] lps_sig_entry(input int unsigned u,
		input int unsigned depth);
		longint unsigned zq;
		longint unsigned a;
		longint unsigned n;
		longint unsigned f;
		longint unsigned sum;
		longint unsigned term;
		longint unsigned den;
		longint unsigned ent;
		logic pos;
		zq = lps_udiv(64'(u) * 64'd786432, 64'(depth));
		pos = zq >= 64'd196608;
		a = pos ? zq - 64'd196608 : 64'd196608 - zq;
		n = a >> 16;
		f = a & 64'hFFFF;
		sum = Q30_ONE;
		term = Q30_ONE;
		for (int k = 1; k <= 10; k++) begin
			term = lps_udiv(term * f, 64'd65536 * 64'(k));
			if ((k & 1) != 0) sum = sum - term;
			else sum = sum + term;
		end
		for (longint unsigned j = 0; j < n; j++) sum = (sum * E_INV_Q30) >> 30;
		den = Q30_ONE + sum;
		if (pos) ent = lps_udiv((64'd1 << 46) + (den >> 1), den);
		else ent = lps_udiv((sum << 16) + (den >> 1), den);
		return ent[SIG_W-1:0];
	endfunction

endpackage

### rtl/lps_chan_if.sv
// Valid/ready channel interface carrying one payload item.
interface lps_chan_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
	modport mon(input valid, input ready, input data);
endinterface

### rtl/lps_root_div.sv
// Iterative unit: floor square root of a squared distance, then 65536 / root.
module lps_root_div import lps_pkg::*; #(
	parameter int SQW = 36
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [SQW-1:0] value,
	output logic           done,
	output logic [16:0]    quotient
);

	localparam int RW = SQW / 2;
	localparam int RMW = RW + 3;
	localparam int CNTW = $clog2(((RW > 17) ? RW : 17) + 1);

	typedef enum logic [2:0] {
		R_IDLE = 3'b001,
		R_SQRT = 3'b010,
		R_DIV  = 3'b100
	} rstate_t;

	rstate_t         state_q;
	logic [SQW-1:0]  val_q;
	logic [RMW-1:0]  rem_q;
	logic [RW-1:0]   root_q;
	logic [RW:0]     drem_q;
	logic [16:0]     num_q;
	logic [16:0]     quot_q;
	logic [CNTW-1:0] cnt_q;
	logic            done_q;

	logic [RMW-1:0] rem_t;
	logic [RMW-1:0] trial;
	logic [RW:0]    drem_t;
	logic           dge;

	always_comb begin
		rem_t = {rem_q[RMW-3:0], val_q[SQW-1:SQW-2]};
		trial = RMW'({root_q, 2'b01});
		drem_t = {drem_q[RW-1:0], num_q[16]};
		dge = drem_t >= {1'b0, root_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= R_IDLE;
			val_q <= '0;
			rem_q <= '0;
			root_q <= '0;
			drem_q <= '0;
			num_q <= '0;
			quot_q <= '0;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				R_IDLE: if (start) begin
					val_q <= value;
					rem_q <= '0;
					root_q <= '0;
					cnt_q <= CNTW'(RW - 1);
					state_q <= R_SQRT;
				end
				R_SQRT: begin
					val_q <= {val_q[SQW-3:0], 2'b00};
					if (rem_t >= trial) begin
						rem_q <= rem_t - trial;
						root_q <= {root_q[RW-2:0], 1'b1};
					end else begin
						rem_q <= rem_t;
						root_q <= {root_q[RW-2:0], 1'b0};
					end
					if (cnt_q == '0) begin
						drem_q <= '0;
						num_q <= 17'h10000;
						cnt_q <= CNTW'(16);
						state_q <= R_DIV;
					end else begin
						cnt_q <= cnt_q - CNTW'(1);
					end
				end
				R_DIV: begin
					num_q <= {num_q[15:0], 1'b0};
					drem_q <= dge ? drem_t - {1'b0, root_q} : drem_t;
					quot_q <= {quot_q[15:0], dge};
					if (cnt_q == '0) begin
						done_q <= 1'b1;
						state_q <= R_IDLE;
					end else begin
						cnt_q <= cnt_q - CNTW'(1);
					end
				end
				default: state_q <= R_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign quotient = quot_q;

endmodule

### rtl/lateral_offset_path_selector.sv
// Lateral offset path selector: sweeps target offsets and picks the cheapest clear path.
// One plan request at a time: request.ready is high only while the sequencer is idle, and a
// finished result sits in an output register so the next request can enter meanwhile.
// All multiplies run on one registered multiplier; roots and divides on an iterative root/divide unit.
// Per candidate, each of the P points walks the table index steps, then the magnitude, dx,
// dy and accumulate states; the index steps derive floor(i*DEPTH/P). A collision-free
// candidate then runs the root/divide unit (start, square root over SQW/2 steps, 17-step
// divide, done) and the 4 cost states, or only the 4 cost states when the nearest point
// is within 0.1 m. P is the point count and DEPTH the sigmoid table depth; the sequencer
// returns to idle before the next request is taken.
// Reset settings give 9 candidates, 15 points, depth 64 and SQW 38.
module lateral_offset_path_selector import lps_pkg::*; #(
	parameter int MAX_POINTS = 32,
	parameter int SIGMOID_TABLE_DEPTH = 64
) (
	input logic        clk,
	input logic        arst_n,
	lps_chan_if.sink   request,
	lps_chan_if.source result,
	lps_chan_if.sink   cfg
);

	localparam int PW = $clog2(MAX_POINTS + 1);
	localparam int CW = (PW > 6) ? PW : 6;
	localparam int IW = $clog2(SIGMOID_TABLE_DEPTH);
	localparam int RW = $clog2(MAX_POINTS + SIGMOID_TABLE_DEPTH);
	localparam int XW = 11 + PW;
	localparam int DW = ((XW + 1 > 16) ? XW + 1 : 16) + 1;
	localparam int MW = (DW > 19) ? DW : 19;
	localparam int SQW = 2 * DW;

	typedef logic [SIG_W-1:0] sig_rom_t [SIGMOID_TABLE_DEPTH];

	function automatic sig_rom_t build_sig_rom();
		sig_rom_t rom;
		for (int u = 0; u < SIGMOID_TABLE_DEPTH; u++) begin
			rom[u] = lps_sig_entry(u, SIGMOID_TABLE_DEPTH);
		end
		return rom;
	endfunction

	localparam sig_rom_t SIG_ROM = build_sig_rom();

	typedef enum logic [14:0] {
		S_IDLE = 15'b000000000000001,
		S_LIM  = 15'b000000000000010,
		S_LIMW = 15'b000000000000100,
		S_CAND = 15'b000000000001000,
		S_IDX  = 15'b000000000010000,
		S_MAG  = 15'b000000000100000,
		S_DX   = 15'b000000001000000,
		S_DY   = 15'b000000010000000,
		S_ACC  = 15'b000000100000000,
		S_ROOT = 15'b000001000000000,
		S_C1   = 15'b000010000000000,
		S_C2   = 15'b000100000000000,
		S_C3   = 15'b001000000000000,
		S_C4   = 15'b010000000000000,
		S_DONE = 15'b100000000000000
	} state_t;

	state_t state_q;

	logic [10:0] max_off_q;
	logic [9:0]  lat_step_q;
	logic [5:0]  pt_cnt_q;
	logic [10:0] lon_step_q;
	logic [9:0]  clear_q;
	logic [11:0] wc_q;
	logic [11:0] wo_q;
	logic [11:0] ws_q;

	logic signed [11:0] last_q;
	logic signed [15:0] ox_q;
	logic signed [15:0] oy_q;
	logic [9:0]         orad_q;
	logic [PW-1:0]      np_q;
	logic [21:0]        lim_q;
	logic signed [12:0] d_q;
	logic signed [11:0] best_d_q;
	logic [23:0]        best_cost_q;
	logic               found_q;
	logic [10:0]        ad_q;
	logic [11:0]        adl_q;
	logic [PW-1:0]      i_q;
	logic [RW-1:0]      r_q;
	logic [IW-1:0]      idx_q;
	logic [XW-1:0]      x_q;
	logic [SQW-1:0]     min2_q;
	logic               hit_q;
	logic signed [DW-1:0] dy_q;
	logic [SQW-1:0]     sq_q;
	logic [17:0]        oc_q;
	logic [31:0]        acc_q;
	logic signed [2*MW-1:0] p_q;
	plan_res_t          res_q;
	logic               res_valid_q;
	logic               rd_start_q;

	logic signed [MW-1:0]   mul_a;
	logic signed [MW-1:0]   mul_b;
	logic signed [2*MW-1:0] mul_p;
	logic [CW-1:0]          pc_ext;
	logic [PW-1:0]          np_sel;
	logic [9:0]             step;
	logic signed [12:0]     max_s;
	logic signed [12:0]     d_nx;
	logic [12:0]            ad_w;
	logic signed [13:0]     dl_w;
	logic [13:0]            adl_w;
	logic [10:0]            csum;
	logic [SIG_W-1:0]       sig_val;
	logic [28:0]            mag_sum;
	logic [12:0]            mag;
	logic signed [DW-1:0]   y_v;
	logic signed [DW-1:0]   dx;
	logic [SQW-1:0]         d2;
	logic [SQW-1:0]         min_n;
	logic                   hit_n;
	logic [PW-1:0]          i_nx;
	logic [31:0]            total;
	logic [32:0]            round_w;
	logic [23:0]            cost_sat;
	logic                   better;
	logic                   res_load;
	logic                   rd_done;
	logic [16:0]            rd_quot;

	lps_root_div #(.SQW(SQW)) u_root_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rd_start_q),
		.value    (min2_q),
		.done     (rd_done),
		.quotient (rd_quot)
	);

	always_comb begin
		pc_ext = CW'(pt_cnt_q);
		if (pc_ext == '0) np_sel = PW'(1);
		else if (pc_ext > CW'(MAX_POINTS)) np_sel = PW'(MAX_POINTS);
		else np_sel = PW'(pc_ext);
		step = (lat_step_q == '0) ? 10'd1 : lat_step_q;
		max_s = $signed({2'b00, max_off_q});
		d_nx = d_q + $signed({3'b000, step});
		ad_w = d_q[12] ? 13'(-d_q) : 13'(d_q);
		dl_w = 14'(d_q) - 14'(last_q);
		adl_w = dl_w[13] ? 14'(-dl_w) : 14'(dl_w);
		csum = 11'(clear_q) + 11'(orad_q);
		sig_val = SIG_ROM[idx_q];
		// round |d|*S back to Q8.8
		mag_sum = 29'(p_q[27:0]) + 29'd32768;
		mag = mag_sum[28:16];
		y_v = d_q[12] ? -DW'($signed({1'b0, mag})) : DW'($signed({1'b0, mag}));
		dx = DW'($signed({1'b0, x_q})) - DW'(ox_q);
		d2 = sq_q + p_q[SQW-1:0];
		min_n = (d2 < min2_q) ? d2 : min2_q;
		hit_n = hit_q | (d2 < SQW'(lim_q));
		i_nx = i_q + PW'(1);
		total = acc_q + p_q[31:0];
		round_w = (33'(total) + 33'd128) >> 8;
		cost_sat = (round_w[32:24] != '0) ? '1 : round_w[23:0];
		better = !found_q || (cost_sat < best_cost_q);
		res_load = (state_q == S_DONE) && (!res_valid_q || result.ready);
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_LIM: begin
				mul_a = MW'($signed({1'b0, csum}));
				mul_b = MW'($signed({1'b0, csum}));
			end
			S_MAG: begin
				mul_a = MW'($signed({1'b0, ad_q}));
				mul_b = MW'($signed({1'b0, sig_val}));
			end
			S_DX: begin
				mul_a = MW'(dx);
				mul_b = MW'(dx);
			end
			S_DY: begin
				mul_a = MW'(dy_q);
				mul_b = MW'(dy_q);
			end
			S_C1: begin
				mul_a = MW'($signed({1'b0, wc_q}));
				mul_b = MW'($signed({1'b0, ad_q}));
			end
			S_C2: begin
				mul_a = MW'($signed({1'b0, wo_q}));
				mul_b = MW'($signed({1'b0, oc_q}));
			end
			S_C3: begin
				mul_a = MW'($signed({1'b0, ws_q}));
				mul_b = MW'($signed({1'b0, adl_q}));
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// configuration registers, always writable
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_off_q <= 11'd512;
			lat_step_q <= 10'd128;
			pt_cnt_q <= 6'd15;
			lon_step_q <= 11'd256;
			clear_q <= 10'd128;
			wc_q <= 12'd128;
			wo_q <= 12'd256;
			ws_q <= 12'd77;
		end else if (cfg.valid) begin
			unique case (cfg.data.index)
				REG_MAX_OFFSET:  max_off_q <= cfg.data.value[10:0];
				REG_LAT_STEP:    lat_step_q <= cfg.data.value[9:0];
				REG_POINT_COUNT: pt_cnt_q <= cfg.data.value[5:0];
				REG_LON_STEP:    lon_step_q <= cfg.data.value[10:0];
				REG_CLEARANCE:   clear_q <= cfg.data.value[9:0];
				REG_W_CENTER:    wc_q <= cfg.data.value;
				REG_W_OBSTACLE:  wo_q <= cfg.data.value;
				REG_W_SMOOTH:    ws_q <= cfg.data.value;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			last_q <= '0;
			ox_q <= '0;
			oy_q <= '0;
			orad_q <= '0;
			np_q <= '0;
			lim_q <= '0;
			d_q <= '0;
			best_d_q <= '0;
			best_cost_q <= '0;
			found_q <= 1'b0;
			ad_q <= '0;
			adl_q <= '0;
			i_q <= '0;
			r_q <= '0;
			idx_q <= '0;
			x_q <= '0;
			min2_q <= '0;
			hit_q <= 1'b0;
			dy_q <= '0;
			sq_q <= '0;
			oc_q <= '0;
			acc_q <= '0;
			p_q <= '0;
			res_q <= '0;
			res_valid_q <= 1'b0;
			rd_start_q <= 1'b0;
		end else begin
			p_q <= mul_p;
			rd_start_q <= 1'b0;
			if (res_load) res_valid_q <= 1'b1;
			else if (result.ready) res_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (request.valid) begin
					ox_q <= request.data.obstacle_x;
					oy_q <= request.data.obstacle_y;
					orad_q <= request.data.obstacle_radius;
					np_q <= np_sel;
					d_q <= -max_s;
					found_q <= 1'b0;
					state_q <= S_LIM;
				end
				S_LIM: state_q <= S_LIMW;
				S_LIMW: begin
					lim_q <= p_q[21:0];
					state_q <= S_CAND;
				end
				S_CAND: begin
					if (d_q > max_s) begin
						state_q <= S_DONE;
					end else begin
						ad_q <= ad_w[10:0];
						adl_q <= adl_w[11:0];
						i_q <= '0;
						r_q <= '0;
						idx_q <= '0;
						x_q <= '0;
						min2_q <= '1;
						hit_q <= 1'b0;
						state_q <= S_IDX;
					end
				end
				// table index floor(i*DEPTH/P) kept as quotient and remainder
				S_IDX: begin
					if (r_q >= RW'(np_q)) begin
						r_q <= r_q - RW'(np_q);
						idx_q <= idx_q + IW'(1);
					end else begin
						state_q <= S_MAG;
					end
				end
				S_MAG: state_q <= S_DX;
				S_DX: begin
					dy_q <= y_v - DW'(oy_q);
					state_q <= S_DY;
				end
				S_DY: begin
					sq_q <= p_q[SQW-1:0];
					state_q <= S_ACC;
				end
				S_ACC: begin
					min2_q <= min_n;
					hit_q <= hit_n;
					x_q <= x_q + XW'(lon_step_q);
					i_q <= i_nx;
					r_q <= r_q + RW'(SIGMOID_TABLE_DEPTH);
					if (i_nx != np_q) begin
						state_q <= S_IDX;
					end else if (hit_n) begin
						d_q <= d_nx;
						state_q <= S_CAND;
					end else if (min_n <= SQW'(NEAR_D2_MAX)) begin
						oc_q <= NEAR_COST;
						state_q <= S_C1;
					end else begin
						rd_start_q <= 1'b1;
						state_q <= S_ROOT;
					end
				end
				S_ROOT: if (rd_done) begin
					oc_q <= {1'b0, rd_quot};
					state_q <= S_C1;
				end
				S_C1: state_q <= S_C2;
				S_C2: begin
					acc_q <= p_q[31:0];
					state_q <= S_C3;
				end
				S_C3: begin
					acc_q <= total;
					state_q <= S_C4;
				end
				S_C4: begin
					if (better) begin
						found_q <= 1'b1;
						best_cost_q <= cost_sat;
						best_d_q <= d_q[11:0];
					end
					d_q <= d_nx;
					state_q <= S_CAND;
				end
				S_DONE: if (res_load) begin
					res_q.best_offset <= found_q ? best_d_q : last_q;
					res_q.best_cost <= found_q ? best_cost_q : '0;
					res_q.path_found <= found_q;
					if (found_q) last_q <= best_d_q;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign request.ready = (state_q == S_IDLE);
	assign result.valid = res_valid_q;
	assign result.data = res_q;
	assign cfg.ready = 1'b1;

endmodule

### rtl/lps_checker.sv
// Port-level checker for the lateral offset path selector, bound to the top level.
`include "lateral_offset_path_selector_assert.svh"

module lps_checker import lps_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      request_valid,
	input logic      request_ready,
	input logic      result_valid,
	input logic      result_ready,
	input plan_res_t result_data
);

	`LPS_ASSERT_NEXT(a_res_hold, result_valid && !result_ready, result_valid && $stable(result_data), "stalled result item changed")
	`LPS_ASSERT_NEXT(a_busy_after_accept, request_valid && request_ready, !request_ready, "ready stayed high after a request item")
	`LPS_ASSERT_SAME(a_no_path_zero_cost, result_valid && !result_data.path_found, result_data.best_cost == 24'd0, "cost nonzero without a path")
	`LPS_ASSERT_SAME(a_offset_range, result_valid, result_data.best_offset != 12'h800, "offset out of range")

endmodule

bind lateral_offset_path_selector lps_checker u_lps_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.request_valid (request.valid),
	.request_ready (request.ready),
	.result_valid  (result.valid),
	.result_ready  (result.ready),
	.result_data   (result.data)
);

### verif/lateral_offset_path_selector_test.sv
// Testbench for the lateral offset path selector: directed table, then random phases.
`timescale 1ns / 1ps
module lateral_offset_path_selector_test;
	import lps_pkg::*;

	localparam int ROM_DEPTH = 64;
	localparam int POINT_CAP = 32;
	localparam longint CYCLE_LIMIT = 40000000;

	typedef struct {
		plan_req_t req;
		bit        typed;
		plan_res_t res;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	lps_chan_if #(.T(plan_req_t)) request_ch();
	lps_chan_if #(.T(plan_res_t)) result_ch();
	lps_chan_if #(.T(cfg_wr_t))   cfg_ch();

	lateral_offset_path_selector #(
		.MAX_POINTS(POINT_CAP),
		.SIGMOID_TABLE_DEPTH(ROM_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.request(request_ch),
		.result(result_ch),
		.cfg(cfg_ch)
	);

	always #6 clk = ~clk;

	// planner registers and state as the block should hold them
	longint unsigned sweep_max, sweep_step, pts, lon_step, clear_r, w_ctr, w_obs, w_smo;
	longint last_off;
	longint unsigned sig_rom[ROM_DEPTH];

	plan_res_t pending_plans[$];
	int mismatches = 0;
	int stall_pct = 0;
	int stall_pct_send = 0;
	bit hold = 1'b0;
	longint cycles = 0;

	function automatic void build_sig_rom();
		longint unsigned zq, a, n, f, sum, term, den;
		bit pos;
		for (int u = 0; u < ROM_DEPTH; u++) begin
			zq = (longint'(u) * 786432) / ROM_DEPTH;
			pos = zq >= 196608;
			a = pos ? zq - 196608 : 196608 - zq;
			n = a >> 16;
			f = a & 16'hFFFF;
			sum = 64'd1 << 30;
			term = 64'd1 << 30;
			for (int k = 1; k <= 10; k++) begin
				term = (term * f) / (64'd65536 * k);
				if (k % 2 == 1) sum = sum - term;
				else sum = sum + term;
			end
			for (longint unsigned j = 0; j < n; j++) sum = (sum * 64'd395007542) >> 30;
			den = (64'd1 << 30) + sum;
			if (pos) sig_rom[u] = ((64'd1 << 46) + den / 2) / den;
			else sig_rom[u] = ((sum << 16) + den / 2) / den;
		end
	endfunction

	function automatic longint unsigned floor_sqrt(longint unsigned v);
		longint unsigned r, bitv;
		r = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= r + bitv) begin
				v -= r + bitv;
				r = (r >> 1) + bitv;
			end else begin
				r >>= 1;
			end
			bitv >>= 2;
		end
		return r;
	endfunction

	// sweep all offsets, pick cheapest clear path, update last offset
	function automatic plan_res_t plan_path(plan_req_t q);
		longint ox, oy, d, stp, np, best_d, ad, adl, mag, y, x, dx, dy;
		longint unsigned lim, min2, d2, oc, cost, best_cost;
		bit hit, found;
		plan_res_t r;
		ox = q.obstacle_x;
		oy = q.obstacle_y;
		stp = sweep_step == 0 ? 1 : sweep_step;
		np = pts == 0 ? 1 : (pts > POINT_CAP ? POINT_CAP : pts);
		lim = (clear_r + q.obstacle_radius) * (clear_r + q.obstacle_radius);
		found = 0;
		best_d = 0;
		best_cost = 0;
		for (d = -longint'(sweep_max); d <= longint'(sweep_max); d += stp) begin
			ad = d < 0 ? -d : d;
			adl = d - last_off;
			if (adl < 0) adl = -adl;
			min2 = '1;
			hit = 0;
			for (longint i = 0; i < np; i++) begin
				mag = (ad * longint'(sig_rom[(i * ROM_DEPTH) / np]) + 32768) >>> 16;
				y = d < 0 ? -mag : mag;
				x = i * longint'(lon_step);
				dx = x - ox;
				dy = y - oy;
				d2 = dx * dx + dy * dy;
				if (d2 < min2) min2 = d2;
				if (d2 < lim) hit = 1;
			end
			if (!hit) begin
				if (min2 * 100 <= 65536) oc = 256000;
				else oc = 65536 / floor_sqrt(min2);
				cost = (w_ctr * ad + w_obs * oc + w_smo * adl + 128) >> 8;
				if (cost > 24'hFFFFFF) cost = 24'hFFFFFF;
				if (!found || cost < best_cost) begin
					found = 1;
					best_cost = cost;
					best_d = d;
				end
			end
		end
		if (found) last_off = best_d;
		r.best_offset = found ? best_d[11:0] : last_off[11:0];
		r.best_cost = found ? best_cost[23:0] : 24'd0;
		r.path_found = found;
		return r;
	endfunction

	// leaves valid high; the caller drops it after the last write
	task automatic write_reg(cfg_reg_t idx, logic [11:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= '{index: idx, value: val};
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			REG_MAX_OFFSET:  sweep_max = val & 12'h7FF;
			REG_LAT_STEP:    sweep_step = val & 12'h3FF;
			REG_POINT_COUNT: pts = val & 12'h03F;
			REG_LON_STEP:    lon_step = val & 12'h7FF;
			REG_CLEARANCE:   clear_r = val & 12'h3FF;
			REG_W_CENTER:    w_ctr = val;
			REG_W_OBSTACLE:  w_obs = val;
			REG_W_SMOOTH:    w_smo = val;
		endcase
	endtask

	task automatic send_plan(plan_req_t q, bit typed, plan_res_t typed_res);
		int gap;
		gap = 0;
		while ($urandom_range(99) < stall_pct_send) gap++;
		if (gap > 0) begin
			request_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		request_ch.valid <= 1'b1;
		request_ch.data <= q;
		do @(posedge clk); while (!request_ch.ready);
		if (typed) begin
			void'(plan_path(q));
			pending_plans.insert(pending_plans.size(), typed_res);
		end else begin
			pending_plans.insert(pending_plans.size(), plan_path(q));
		end
	endtask

	function automatic plan_req_t random_obstacle();
		plan_req_t q;
		longint np, x, y;
		np = pts == 0 ? 1 : (pts > POINT_CAP ? POINT_CAP : pts);
		if ($urandom_range(99) < 40) begin
			q.obstacle_x = 16'($urandom);
			q.obstacle_y = 16'($urandom);
			q.obstacle_radius = 10'($urandom);
		end else begin
			// somewhere near the swept lattice
			x = $urandom_range(0, np - 1) * longint'(lon_step) + $urandom_range(0, 600) - 300;
			y = longint'($urandom_range(0, 2 * sweep_max + 512)) - longint'(sweep_max) - 256;
			if (x > 32767) x = 32767;
			q.obstacle_x = x[15:0];
			q.obstacle_y = y[15:0];
			q.obstacle_radius = 10'($urandom_range(0, 80));
		end
		return q;
	endfunction

	task automatic drain();
		request_ch.valid <= 1'b0;
		while (pending_plans.size() != 0) @(posedge clk);
	endtask

	// receiver
	always @(posedge clk) begin
		result_ch.ready <= hold ? 1'b0 : ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		plan_res_t e;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_plans.size() == 0) begin
				$error("result with no plan outstanding");
				mismatches++;
			end else begin
				e = pending_plans.pop_front();
				if (result_ch.data.best_offset !== e.best_offset) begin
					$error("best_offset exp %0d got %0d", e.best_offset,
						result_ch.data.best_offset);
					mismatches++;
				end
				if (result_ch.data.best_cost !== e.best_cost) begin
					$error("best_cost exp %0d got %0d", e.best_cost, result_ch.data.best_cost);
					mismatches++;
				end
				if (result_ch.data.path_found !== e.path_found) begin
					$error("path_found exp %0d got %0d", e.path_found,
						result_ch.data.path_found);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("lateral_offset_path_selector_test: FAIL");
			$finish;
		end
	end

	plan_row_t directed[$];

	function automatic void add_row(logic signed [15:0] x, logic signed [15:0] y,
		logic [9:0] rad, bit typed, plan_res_t res);
		plan_row_t row;
		row.req.obstacle_x = x;
		row.req.obstacle_y = y;
		row.req.obstacle_radius = rad;
		row.typed = typed;
		row.res = res;
		directed.insert(directed.size(), row);
	endfunction

	initial begin
		plan_res_t none;
		logic [11:0] v[8];
		int mode;
		request_ch.valid = 1'b0;
		request_ch.data = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '{index: REG_MAX_OFFSET, value: 12'd0};
		result_ch.ready = 1'b0;
		sweep_max = 512; sweep_step = 128; pts = 15; lon_step = 256;
		clear_r = 128; w_ctr = 128; w_obs = 256; w_smo = 77;
		last_off = 0;
		build_sig_rom();
		none = '{best_offset: 12'sd0, best_cost: 24'd0, path_found: 1'b0};
		// obstacle sits on the start point: every candidate collides
		add_row(16'sd0, 16'sd0, 10'd1023, 1, none);
		add_row(16'sd256, 16'sd0, 10'd1023, 1, none);
		add_row(16'sd32767, 16'sd32767, 10'd0, 0, none);
		add_row(-16'sd32768, -16'sd32768, 10'd0, 0, none);
		add_row(-16'sd32768, 16'sd32767, 10'd1023, 0, none);
		add_row(16'sd32767, -16'sd32768, 10'd1023, 0, none);
		add_row(16'sd512, 16'sd0, 10'd64, 0, none);
		add_row(16'sd1024, 16'sd300, 10'd0, 0, none);
		add_row(16'sd2000, -16'sd400, 10'd10, 0, none);
		add_row(16'sd0, 16'sd700, 10'd0, 0, none);
		add_row(16'sd3584, 16'sd512, 10'd0, 0, none);
		add_row(16'sd3584, -16'sd512, 10'd0, 0, none);
		add_row(-16'sd1, 16'sd1, 10'd1, 0, none);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[k]) send_plan(directed[k].req, directed[k].typed, directed[k].res);
		drain();

		for (int ph = 0; ph < 12; ph++) begin
			if (ph == 0) v = '{12'd2047, 12'd1023, 12'd63, 12'd2047, 12'd1023,
				12'd4095, 12'd4095, 12'd4095};
			else if (ph == 1) v = '{12'd0, 12'd0, 12'd0, 12'd1, 12'd0, 12'd0, 12'd0, 12'd0};
			else if (ph == 2) v = '{12'd24, 12'd1, 12'd32, 12'd300, 12'd0, 12'd200, 12'd300,
				12'd100};
			else begin
				v[1] = 12'($urandom_range(0, 1023));
				v[0] = 12'($urandom_range(0, (v[1] == 0 ? 1 : v[1]) * 4 > 2047 ? 2047
					: (v[1] == 0 ? 1 : v[1]) * 4));
				v[2] = 12'($urandom_range(0, 40));
				v[3] = 12'($urandom_range(1, 2047));
				v[4] = $urandom_range(0, 3) == 0 ? 12'd0 : 12'($urandom_range(0, 1023));
				v[5] = 12'($urandom_range(0, 4095));
				v[6] = 12'($urandom_range(0, 4095));
				v[7] = 12'($urandom_range(0, 4095));
			end
			for (int r = 0; r < 8; r++) write_reg(cfg_reg_t'(r), v[r]);
			cfg_ch.valid <= 1'b0;
			mode = ph % 4;
			stall_pct_send = mode == 1 ? 81 : (mode == 3 ? 12 : 0);
			stall_pct = mode == 2 ? 81 : (mode == 3 ? 12 : 0);
			if (ph == 5) begin
				fork
					begin
						hold = 1'b1;
						repeat (8000) @(posedge clk);
						hold = 1'b0;
					end
				join_none
			end
			for (int n = 0; n < (ph == 2 ? 20 : 107); n++) send_plan(random_obstacle(), 0, none);
			drain();
		end

		repeat (50) @(posedge clk);
		if (mismatches == 0) $display("lateral_offset_path_selector_test: PASS");
		else $display("lateral_offset_path_selector_test: FAIL");
		$finish;
	end

endmodule

### filelist.f
+incdir+rtl
rtl/lps_pkg.sv
rtl/lps_chan_if.sv
rtl/lps_root_div.sv
rtl/lateral_offset_path_selector.sv
rtl/lps_checker.sv
verif/lateral_offset_path_selector_test.sv
